// ===== rtl/core/dsut_pkg.sv =====
// Shared types and codes for the dedup set union table.
// No dependencies; used by dsut_seq and dedup_set_union_table_unit.
package dsut_pkg;

    // Word widths on the stream and configuration ports
    localparam int IN_DATA_W  = 56;   // action + node_key, padded to bytes
    localparam int OUT_DATA_W = 16;   // status + slot_index + entry_total
    localparam int CFG_W      = 7;    // capacity_limit
    localparam int NODE_KEY_W = 48;
    localparam int SLOT_W     = 6;
    localparam int TOTAL_W    = 7;

    localparam logic [CFG_W-1:0] CAP_RESET = 7'd64;

    // Action codes
    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_ADD   = 2'd1;
    localparam logic [1:0] ACT_FIND  = 2'd2;

    // Result status codes
    typedef enum logic [2:0] {
        ST_ADDED   = 3'd0,
        ST_DUP     = 3'd1,
        ST_NOROOM  = 3'd2,
        ST_FOUND   = 3'd3,
        ST_MISSING = 3'd4,
        ST_CLEARED = 3'd5
    } status_t;

    // Result handed from the sequencer to the output register
    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic [SLOT_W-1:0]  slot;
        status_t            status;
    } result_t;

endpackage

// ===== rtl/core/dedup_set_union_table_unit.sv =====
// Top level of the dedup set union table: stream ports, capacity register,
// output register. Depends on dsut_pkg, dsut_seq and dsut_ram.
//
// Usage:
//   s_ channel carries one command word: clear, add a key to the current
//   batch (s_tlast marks the batch's last add) or find a key. Every clear,
//   add and find gives exactly one m_ word; action 3 is consumed silently.
//   cfg_ channel writes capacity_limit (always ready); write it while idle.
// Scan:
//   A find scans entry_count stored keys, an add scans the entries present
//   when its batch opened, one key per cycle through the single RAM read
//   port and one comparator; the scan stops at the first match (at most
//   SET_DEPTH keys). A clear or an add of a failed batch skips the scan.
//   s_tready is high only while the sequencer is idle, so a new word is not
//   taken before the previous result has passed to the output register.
// Reset: aresetn (synchronous) empties the set, closes any batch and sets
//   capacity_limit to 64. Key RAM contents are not cleared; no clearing pass.
// Stall: a result waits in the output register; the next word can be
//   accepted meanwhile, and its result is held until m_tready frees the slot.
module dedup_set_union_table_unit #(
    parameter int SET_DEPTH = 64,
    parameter int KEY_BITS  = 48
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input words
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [dsut_pkg::IN_DATA_W-1:0]    s_tdata,   // action[1:0], node_key[49:2]
    input  logic                              s_tlast,   // end_of_batch
    // result words
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [dsut_pkg::OUT_DATA_W-1:0]   m_tdata,   // status[2:0], slot_index[8:3],
                                                         // entry_total[15:9]
    // configuration
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dsut_pkg::CFG_W-1:0]        cfg_data   // capacity_limit
);

    localparam int IDX_W = $clog2(SET_DEPTH);

    logic [dsut_pkg::CFG_W-1:0] cap_reg;
    logic [KEY_BITS-1:0]        in_key;
    logic                       res_valid;
    logic                       res_ready;
    dsut_pkg::result_t          res;
    logic                       m_valid_reg;
    dsut_pkg::result_t          m_data_reg;
    logic                       rd_en;
    logic [IDX_W-1:0]           rd_addr;
    logic [KEY_BITS-1:0]        rd_data;
    logic                       wr_en;
    logic [IDX_W-1:0]           wr_addr;
    logic [KEY_BITS-1:0]        wr_data;

    // key field sized to the stored key width
    generate
        if (KEY_BITS <= dsut_pkg::NODE_KEY_W) begin : g_key_trunc
            assign in_key = s_tdata[KEY_BITS+1:2];
        end else begin : g_key_ext
            assign in_key = {{(KEY_BITS - dsut_pkg::NODE_KEY_W){1'b0}}, s_tdata[49:2]};
        end
    endgenerate

    // capacity register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= dsut_pkg::CAP_RESET;
        end else if (cfg_valid) begin
            cap_reg <= cfg_data;
        end
    end

    dsut_seq #(
        .SET_DEPTH (SET_DEPTH),
        .KEY_BITS  (KEY_BITS)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_action (s_tdata[1:0]),
        .in_key    (in_key),
        .in_last   (s_tlast),
        .cap_limit (cap_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    dsut_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (SET_DEPTH)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // output register
    assign res_ready = !m_valid_reg || m_tready;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end
    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_data_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== rtl/core/dsut_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dsut_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/dsut_seq.sv =====
// Sequencer for the dedup set union table: batch state, entry count and the
// one-key-per-cycle scan/compare unit over the key RAM.
// Depends on dsut_pkg.
module dsut_seq #(
    parameter int SET_DEPTH = 64,
    parameter int KEY_BITS  = 48
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // incoming item
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   in_action,
    input  logic [KEY_BITS-1:0]          in_key,
    input  logic                         in_last,
    input  logic [dsut_pkg::CFG_W-1:0]   cap_limit,
    // result toward the output register
    output logic                         res_valid,
    input  logic                         res_ready,
    output dsut_pkg::result_t            res,
    // key RAM
    output logic                         rd_en,
    output logic [$clog2(SET_DEPTH)-1:0] rd_addr,
    input  logic [KEY_BITS-1:0]          rd_data,
    output logic                         wr_en,
    output logic [$clog2(SET_DEPTH)-1:0] wr_addr,
    output logic [KEY_BITS-1:0]          wr_data
);

    localparam int IDX_W = $clog2(SET_DEPTH);
    localparam int CNT_W = $clog2(SET_DEPTH + 1);
    localparam int CMP_W = (CNT_W > dsut_pkg::CFG_W) ? CNT_W : dsut_pkg::CFG_W;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DECIDE = 4'b0100,
        S_DONE   = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    base_reg, base_next;
    logic                open_reg, open_next;
    logic                failed_reg, failed_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic                find_reg, find_next;
    logic                last_reg, last_next;
    logic [CNT_W-1:0]    limit_reg, limit_next;
    logic [CNT_W-1:0]    issue_reg, issue_next;
    logic                pend_reg, pend_next;
    logic [IDX_W-1:0]    pend_idx_reg, pend_idx_next;
    logic                hit_reg, hit_next;
    logic [IDX_W-1:0]    hit_idx_reg, hit_idx_next;
    dsut_pkg::status_t   res_status_reg, res_status_next;
    logic [dsut_pkg::SLOT_W-1:0] res_slot_reg, res_slot_next;

    logic                scan_rd;
    logic                hit_now;
    logic [CMP_W-1:0]    cap_eff;
    logic                has_room;
    logic                eff_failed;
    logic [CNT_W-1:0]    eff_base;

    // capacity clamped to the depth, and room check
    always_comb begin
        if (CMP_W'(cap_limit) > CMP_W'(SET_DEPTH)) begin
            cap_eff = CMP_W'(SET_DEPTH);
        end else begin
            cap_eff = CMP_W'(cap_limit);
        end
    end
    assign has_room = CMP_W'(count_reg) < cap_eff;

    // batch view seen by an add arriving now
    assign eff_failed = open_reg ? failed_reg : 1'b0;
    assign eff_base   = open_reg ? base_reg : count_reg;

    // scan unit: one read issued and one compare per cycle
    assign hit_now = pend_reg && (rd_data == key_reg);
    assign scan_rd = (state_reg == S_SCAN) && (issue_reg < limit_reg) && !hit_now;
    assign rd_en   = scan_rd;
    assign rd_addr = issue_reg[IDX_W-1:0];

    // next-state logic
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        base_next       = base_reg;
        open_next       = open_reg;
        failed_next     = failed_reg;
        key_next        = key_reg;
        find_next       = find_reg;
        last_next       = last_reg;
        limit_next      = limit_reg;
        issue_next      = issue_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        wr_en           = 1'b0;
        wr_addr         = count_reg[IDX_W-1:0];
        wr_data         = key_reg;

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    key_next   = in_key;
                    last_next  = in_last;
                    issue_next = '0;
                    pend_next  = 1'b0;
                    hit_next   = 1'b0;
                    case (in_action)
                        dsut_pkg::ACT_CLEAR: begin
                            count_next      = '0;
                            base_next       = '0;
                            open_next       = 1'b0;
                            failed_next     = 1'b0;
                            res_status_next = dsut_pkg::ST_CLEARED;
                            res_slot_next   = '0;
                            state_next      = S_DONE;
                        end
                        dsut_pkg::ACT_FIND: begin
                            find_next  = 1'b1;
                            limit_next = count_reg;
                            state_next = S_SCAN;
                        end
                        dsut_pkg::ACT_ADD: begin
                            find_next   = 1'b0;
                            open_next   = 1'b1;
                            base_next   = eff_base;
                            failed_next = eff_failed;
                            limit_next  = eff_base;
                            if (eff_failed) begin
                                // rest of a failed batch is dropped
                                res_status_next = dsut_pkg::ST_NOROOM;
                                res_slot_next   = '0;
                                state_next      = S_DONE;
                                if (in_last) begin
                                    open_next   = 1'b0;
                                    failed_next = 1'b0;
                                end
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        default: begin
                            // unknown action: consumed, no result
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                pend_next     = scan_rd;
                pend_idx_next = issue_reg[IDX_W-1:0];
                if (scan_rd) begin
                    issue_next = issue_reg + 1'b1;
                end
                if (hit_now) begin
                    hit_next     = 1'b1;
                    hit_idx_next = pend_idx_reg;
                    pend_next    = 1'b0;
                    state_next   = S_DECIDE;
                end else if (!scan_rd && !pend_reg) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                state_next = S_DONE;
                if (find_reg) begin
                    res_status_next = hit_reg ? dsut_pkg::ST_FOUND : dsut_pkg::ST_MISSING;
                    res_slot_next   = hit_reg ? dsut_pkg::SLOT_W'(hit_idx_reg) : '0;
                end else begin
                    if (hit_reg) begin
                        res_status_next = dsut_pkg::ST_DUP;
                        res_slot_next   = dsut_pkg::SLOT_W'(hit_idx_reg);
                    end else if (has_room) begin
                        wr_en           = 1'b1;
                        count_next      = count_reg + 1'b1;
                        res_status_next = dsut_pkg::ST_ADDED;
                        res_slot_next   = dsut_pkg::SLOT_W'(count_reg);
                    end else begin
                        failed_next     = 1'b1;
                        res_status_next = dsut_pkg::ST_NOROOM;
                        res_slot_next   = '0;
                    end
                    if (last_reg) begin
                        open_next   = 1'b0;
                        failed_next = 1'b0;
                    end
                end
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            base_reg   <= '0;
            open_reg   <= 1'b0;
            failed_reg <= 1'b0;
            pend_reg   <= 1'b0;
            hit_reg    <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            base_reg   <= base_next;
            open_reg   <= open_next;
            failed_reg <= failed_next;
            pend_reg   <= pend_next;
            hit_reg    <= hit_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        key_reg        <= key_next;
        find_reg       <= find_next;
        last_reg       <= last_next;
        limit_reg      <= limit_next;
        issue_reg      <= issue_next;
        pend_idx_reg   <= pend_idx_next;
        hit_idx_reg    <= hit_idx_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_DONE);
    assign res.status = res_status_reg;
    assign res.slot   = res_slot_reg;
    assign res.total  = dsut_pkg::TOTAL_W'(count_reg);

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(SET_DEPTH))
        else $error("entry count above set depth");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != $past(count_reg) |->
            (count_reg == $past(count_reg) + 1'b1) || (count_reg == '0))
        else $error("entry count moved other than by one or clear");

    a_failed_open: assert property (@(posedge aclk) disable iff (!aresetn)
        failed_reg |-> open_reg)
        else $error("failed flag set with no open batch");

    a_scan_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (issue_reg <= limit_reg))
        else $error("scan ran past its limit");

    a_write_room: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg == S_DECIDE) && (count_reg < CNT_W'(SET_DEPTH)))
        else $error("key write outside decide or beyond depth");
`endif

endmodule

// ===== dv/dedup_set_union_table_unit_tb.sv =====
// Self-checking testbench for dedup_set_union_table_unit: a directed pass, then
// random add batches, finds and clears under several capacity settings.
// Depends on dsut_pkg and the RTL of the unit; reads no files.
`timescale 1ns / 100ps

module dedup_set_union_table_unit_tb;
    import dsut_pkg::*;

    localparam int SET_SLOTS   = 64;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_WAIT  = 100;      // outlasts the worst-case scan of a full table
    localparam logic [1:0] ACT_NONE = 2'd3; // consumed without a result word

    typedef struct {
        logic [1:0]            action;
        logic [NODE_KEY_W-1:0] key;
        logic                  last;
    } cmd_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      cfg_data  = '0;

    // Predicted table state
    bit [NODE_KEY_W-1:0] table_keys [SET_SLOTS];
    bit [TOTAL_W-1:0]    table_count;
    bit [TOTAL_W-1:0]    batch_base;
    bit                  batch_open;
    bit                  batch_failed;
    bit [CFG_W-1:0]      cap_limit;

    // Stimulus and checking bookkeeping
    cmd_t                cmd_fifo [$];
    cmd_t                drv_cmd;
    result_t             predicted_replies [$];
    bit [NODE_KEY_W-1:0] key_pool [16];
    int                  words_queued;
    int                  words_taken;
    int                  mismatches;
    int                  cycle_count;
    int                  src_gap;
    int                  sink_gap;
    bit                  word_accepted;
    bit                  idle_on;

    dedup_set_union_table_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Lowest slot below lim that holds key
    function automatic bit scan_table(input bit [NODE_KEY_W-1:0] key,
                                      input bit [TOTAL_W-1:0] lim,
                                      output bit [SLOT_W-1:0] slot);
        int i;
        slot = '0;
        for (i = 0; i < lim && i < SET_SLOTS; i++) begin
            if (table_keys[i] == key) begin
                slot = SLOT_W'(i);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Applies one command to the predicted table; returns 1 if a word results
    function automatic bit table_step(input cmd_t c, output result_t r);
        bit [SLOT_W-1:0]  slot;
        bit [TOTAL_W-1:0] cap;
        r = '0;
        case (c.action)
            ACT_CLEAR: begin
                table_count  = '0;
                batch_base   = '0;
                batch_open   = 1'b0;
                batch_failed = 1'b0;
                r.status     = ST_CLEARED;
            end
            ACT_FIND: begin
                if (scan_table(c.key, table_count, slot)) begin
                    r.status = ST_FOUND;
                    r.slot   = slot;
                end else begin
                    r.status = ST_MISSING;
                end
            end
            ACT_ADD: begin
                if (!batch_open) begin
                    batch_open   = 1'b1;
                    batch_failed = 1'b0;
                    batch_base   = table_count;
                end
                cap = (cap_limit > SET_SLOTS) ? TOTAL_W'(SET_SLOTS) : cap_limit;
                if (batch_failed) begin
                    r.status = ST_NOROOM;
                end else if (scan_table(c.key, batch_base, slot)) begin
                    r.status = ST_DUP;
                    r.slot   = slot;
                end else if (table_count < cap) begin
                    table_keys[table_count] = c.key;
                    r.status    = ST_ADDED;
                    r.slot      = SLOT_W'(table_count);
                    table_count = table_count + 1'b1;
                end else begin
                    batch_failed = 1'b1;
                    r.status     = ST_NOROOM;
                end
                if (c.last) begin
                    batch_open   = 1'b0;
                    batch_failed = 1'b0;
                end
            end
            default: return 1'b0;
        endcase
        r.total = table_count;
        return 1'b1;
    endfunction

    function automatic void report_mismatch(input string what, input result_t want,
                                            input result_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected status %0d slot %0d total %0d, got status %0d slot %0d total %0d",
                     $time, what, want.status, want.slot, want.total,
                     got.status, got.slot, got.total);
    endfunction

    // Source: one word in flight, random idle bursts while enabled
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !word_accepted) begin
            // word still waiting for s_tready
        end else if (src_gap != 0) begin
            src_gap--;
            s_tvalid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            src_gap = $urandom_range(0, 15);
            s_tvalid <= 1'b0;
        end else if (cmd_fifo.size() != 0) begin
            drv_cmd = cmd_fifo.pop_front();
            s_tvalid <= 1'b1;
            s_tdata  <= {6'b0, drv_cmd.key, drv_cmd.action};
            s_tlast  <= drv_cmd.last;
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Sink: random stall bursts while enabled
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (sink_gap != 0) begin
            sink_gap--;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            sink_gap = $urandom_range(0, 15);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Predict accepted words, check result words in order
    always @(posedge aclk) begin
        result_t want;
        result_t got;
        if (!aresetn) begin
            word_accepted <= 1'b0;
        end else begin
            word_accepted <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                words_taken++;
                if (table_step(drv_cmd, want))
                    predicted_replies.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata);
                if (predicted_replies.size() == 0) begin
                    report_mismatch("unexpected result word", '0, got);
                end else begin
                    want = predicted_replies.pop_front();
                    if (got.status !== want.status || got.slot !== want.slot ||
                        got.total !== want.total)
                        report_mismatch("result mismatch", want, got);
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_cmd(input logic [1:0] action, input logic [NODE_KEY_W-1:0] key,
                            input logic last);
        cmd_t c;
        c.action = action;
        c.key    = key;
        c.last   = last;
        cmd_fifo.push_back(c);
        words_queued++;
    endtask

    // Wait until every word is taken and answered, then let the scan settle
    task automatic wait_idle();
        while (words_taken != words_queued || predicted_replies.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
    endtask

    task automatic cfg_write(input bit [CFG_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cap_limit = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly keys from a small pool so duplicates and hits are common
    function automatic bit [NODE_KEY_W-1:0] pick_key();
        bit [NODE_KEY_W-1:0] k;
        k = NODE_KEY_W'({$urandom, $urandom});
        if ($urandom_range(0, 9) < 6)
            k = key_pool[$urandom_range(0, 15)];
        else if ($urandom_range(0, 3) == 0)
            key_pool[$urandom_range(0, 15)] = k;
        return k;
    endfunction

    // Random mix: batches of adds, finds, clears and some noise
    task automatic random_phase(input int n, input int clear_pct);
        int left;
        int kind;
        int len;
        int i;
        left = n;
        while (left > 0) begin
            kind = $urandom_range(0, 99);
            if (kind < clear_pct) begin
                send_cmd(ACT_CLEAR, pick_key(), 1'($urandom_range(0, 1)));
                left--;
            end else if (kind < clear_pct + 20) begin
                send_cmd(ACT_FIND, pick_key(), 1'($urandom_range(0, 1)));
                left--;
            end else if (kind < clear_pct + 23) begin
                send_cmd(ACT_NONE, pick_key(), 1'($urandom_range(0, 1)));
            end else begin
                len = $urandom_range(1, 8);
                for (i = 0; i < len; i++) begin
                    // a find inside the batch leaves it open
                    if ($urandom_range(0, 19) == 0) begin
                        send_cmd(ACT_FIND, pick_key(), 1'b1);
                        left--;
                    end
                    // one batch in ten runs on without its closing word
                    send_cmd(ACT_ADD, pick_key(),
                             (i == len - 1) && ($urandom_range(0, 9) != 0));
                    left--;
                end
            end
        end
    endtask

    initial begin
        bit [NODE_KEY_W-1:0] fill_keys [70];
        bit [NODE_KEY_W-1:0] ones;
        bit [NODE_KEY_W-1:0] alt;
        int i;

        ones = '1;
        alt  = {24{2'b10}};
        cap_limit = CAP_RESET;
        idle_on   = 1'b0;
        for (i = 0; i < 16; i++)
            key_pool[i] = NODE_KEY_W'({$urandom, $urandom});
        key_pool[0] = '0;
        key_pool[1] = ones;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: batches, in-batch repeats, finds, clear inside a batch
        cfg_write(7'd64);
        send_cmd(ACT_CLEAR, '0, 1'b0);
        send_cmd(ACT_FIND, '0, 1'b0);                 // empty set
        send_cmd(ACT_ADD, '0, 1'b0);
        send_cmd(ACT_ADD, ones, 1'b0);
        send_cmd(ACT_ADD, ones, 1'b0);                // same batch: appended again
        send_cmd(ACT_ADD, ~alt, 1'b1);
        send_cmd(ACT_ADD, '0, 1'b0);                  // duplicate of slot 0
        send_cmd(ACT_FIND, ones, 1'b1);               // tlast ignored, batch stays open
        send_cmd(ACT_ADD, alt, 1'b0);
        send_cmd(ACT_ADD, alt, 1'b1);
        send_cmd(ACT_NONE, ones, 1'b1);
        send_cmd(ACT_FIND, alt, 1'b0);
        send_cmd(ACT_FIND, 48'h1234_5678_9abc, 1'b0);
        send_cmd(ACT_ADD, 48'h0123_4567_89ab, 1'b0);
        send_cmd(ACT_CLEAR, ones, 1'b1);              // closes the open batch
        send_cmd(ACT_ADD, 48'd7, 1'b1);
        wait_idle();

        // Small capacity: batch fails, later adds dropped
        cfg_write(7'd3);
        send_cmd(ACT_ADD, 48'd1, 1'b0);
        send_cmd(ACT_ADD, 48'd7, 1'b0);
        send_cmd(ACT_ADD, 48'd3, 1'b0);
        send_cmd(ACT_ADD, 48'd4, 1'b0);
        send_cmd(ACT_ADD, 48'd7, 1'b0);
        send_cmd(ACT_ADD, 48'd5, 1'b1);
        wait_idle();

        // Capacity below the entry count
        cfg_write(7'd1);
        send_cmd(ACT_ADD, 48'd1, 1'b0);
        send_cmd(ACT_ADD, 48'd9, 1'b1);
        send_cmd(ACT_FIND, 48'd3, 1'b0);
        wait_idle();

        cfg_write(7'd0);
        send_cmd(ACT_CLEAR, '0, 1'b0);
        send_cmd(ACT_ADD, 48'd1, 1'b1);
        wait_idle();

        // Random traffic with idling on both sides
        idle_on = 1'b1;
        cfg_write(7'd64);
        random_phase(450, 5);
        wait_idle();

        // Capacity above depth: fill the whole table, then overflow
        cfg_write(7'd127);
        send_cmd(ACT_CLEAR, '0, 1'b0);
        for (i = 0; i < 70; i++) begin
            fill_keys[i] = NODE_KEY_W'({$urandom, $urandom});
            send_cmd(ACT_ADD, fill_keys[i], i == 69);
        end
        send_cmd(ACT_FIND, fill_keys[63], 1'b0);
        send_cmd(ACT_FIND, fill_keys[64], 1'b0);
        send_cmd(ACT_ADD, fill_keys[10], 1'b1);
        random_phase(250, 2);
        wait_idle();

        cfg_write(7'($urandom_range(2, 70)));
        random_phase(250, 6);
        wait_idle();

        // Last stretch without idling
        idle_on = 1'b0;
        cfg_write(7'd64);
        random_phase(250, 5);
        wait_idle();

        if (mismatches == 0 && predicted_replies.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== dedup_set_union_table_unit.f =====
rtl/core/dsut_pkg.sv
rtl/core/dsut_ram.sv
rtl/core/dsut_seq.sv
rtl/core/dedup_set_union_table_unit.sv
dv/dedup_set_union_table_unit_tb.sv
